[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/strm_pkg.sv]
package strm_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int LEVELS_DEF       = 11;
    localparam int VALUE_BITS_DEF   = 32;

    localparam int OP_W    = 3;
    localparam int POS_W   = 10;
    localparam int LEN_W   = 11;
    localparam int FIELD_W = 32;
    localparam int SRCH_W  = POS_W + 2;

    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 3'd1;
    localparam logic [OP_W-1:0] OP_RMIN    = 3'd2;
    localparam logic [OP_W-1:0] OP_SRCH_LO = 3'd3;
    localparam logic [OP_W-1:0] OP_SRCH_HI = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          left;
        logic [POS_W-1:0]          right;
        logic signed [FIELD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] min_value;
        logic [POS_W-1:0]          position;
        logic                      found;
        logic                      range_error;
    } t_out_item;

    typedef enum logic [1:0] {
        RD_INPUT,
        RD_QUERY,
        RD_BUILD
    } t_rd_sel;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_ERR,
        OUT_RMIN,
        OUT_SRCH
    } t_out_sel;

    typedef struct packed {
        logic     accept;
        logic     load_wr;
        logic     bld_wr;
        logic     bld_next_lvl;
        logic     set_built;
        logic     srch_step;
        logic     out_load;
        t_out_sel out_sel;
        t_rd_sel  rd_sel;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            in_err;
        logic            bld_ok;
        logic            bld_idx_zero;
        logic            srch_more;
    } t_status;

endpackage

[rtl/strm_ctrl.sv]
module strm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  strm_pkg::t_status i_status,
    output strm_pkg::t_cmd   o_cmd
);
    import strm_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMIN,
        S_SCMP,
        S_SRD,
        S_BRD,
        S_BWR,
        S_PUT
    } t_state;

    t_state   r_state, n_state;
    t_out_sel r_put_sel, n_put_sel;
    logic     r_out_valid, n_out_valid;
    logic     out_free;
    logic     imm;
    t_out_sel imm_sel;
    t_cmd     cmd;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        cmd       = '0;
        n_state   = r_state;
        n_put_sel = r_put_sel;
        imm       = 1'b0;
        imm_sel   = OUT_ZERO;
        unique case (r_state)
            S_IDLE: begin
                cmd.rd_sel = RD_INPUT;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    unique case (i_status.in_op)
                        OP_LOAD: begin
                            cmd.load_wr = 1'b1;
                            imm         = 1'b1;
                        end
                        OP_BUILD: begin
                            n_state = S_BRD;
                        end
                        OP_RMIN: begin
                            if (i_status.in_err) begin
                                imm     = 1'b1;
                                imm_sel = OUT_ERR;
                            end else begin
                                n_state = S_RMIN;
                            end
                        end
                        OP_SRCH_LO, OP_SRCH_HI: begin
                            if (i_status.in_err) begin
                                imm     = 1'b1;
                                imm_sel = OUT_ERR;
                            end else begin
                                n_state = S_SCMP;
                            end
                        end
                        default: begin
                            imm = 1'b1;
                        end
                    endcase
                    if (imm) begin
                        if (out_free) begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = imm_sel;
                        end else begin
                            n_put_sel = imm_sel;
                            n_state   = S_PUT;
                        end
                    end
                end
            end
            S_RMIN: begin
                cmd.rd_sel = RD_QUERY;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_RMIN;
                    n_state      = S_IDLE;
                end
            end
            S_SCMP: begin
                cmd.rd_sel    = RD_QUERY;
                cmd.srch_step = 1'b1;
                if (i_status.srch_more) begin
                    n_state = S_SRD;
                end else begin
                    n_put_sel = OUT_SRCH;
                    n_state   = S_PUT;
                end
            end
            S_SRD: begin
                cmd.rd_sel = RD_QUERY;
                n_state    = S_SCMP;
            end
            S_BRD: begin
                cmd.rd_sel = RD_BUILD;
                priority if (i_status.bld_ok) begin
                    n_state = S_BWR;
                end else if (i_status.bld_idx_zero) begin
                    cmd.set_built = 1'b1;
                    n_put_sel     = OUT_ZERO;
                    n_state       = S_PUT;
                end else begin
                    cmd.bld_next_lvl = 1'b1;
                end
            end
            S_BWR: begin
                cmd.rd_sel = RD_BUILD;
                cmd.bld_wr = 1'b1;
                n_state    = S_BRD;
            end
            S_PUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = r_put_sel;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_put_sel   <= OUT_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_put_sel   <= n_put_sel;
            r_out_valid <= n_out_valid;
        end
    end

    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, out_free, "result beat overwritten")
    `ASSERT_NEXT(a_accept_tracked, i_clk, i_rst_n, cmd.accept, (!o_in_ready || o_out_valid), "accepted beat lost")

endmodule

[rtl/strm_datapath.sv]
module strm_datapath #(
    parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = strm_pkg::LEVELS_DEF,
    parameter int VALUE_BITS   = strm_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  strm_pkg::t_in_item         i_in_data,
    input  logic                       i_cfg_wr_en,
    input  logic [strm_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  strm_pkg::t_cmd             i_cmd,
    output strm_pkg::t_status          o_status,
    output strm_pkg::t_out_item        o_out_data
);
    import strm_pkg::*;

    `include "assert_macros.svh"

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int LA_W   = $clog2(LEVELS);
    localparam int LC_W   = $clog2(LEVELS + 1);
    localparam int AW     = LA_W + IDX_W;
    localparam int DEPTH  = LEVELS << IDX_W;
    localparam int CMP_W  = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int SPAN_W = ((LEVELS > LEN_W) ? LEVELS : LEN_W) + 2;
    localparam int FL_W   = $clog2(LEN_W);
    localparam logic signed [SRCH_W-1:0] ONE_S = 1;

    // table: level-major, {level, index}
    logic signed [VALUE_BITS-1:0] r_table [DEPTH];
    logic signed [VALUE_BITS-1:0] r_rd_a, r_rd_b;

    logic [LEN_W-1:0]          r_used_len;
    logic                      r_built;
    logic [OP_W-1:0]           r_op;
    logic signed [FIELD_W-1:0] r_thr;
    logic signed [SRCH_W-1:0]  r_lo, r_hi, n_lo, n_hi;
    logic [POS_W-1:0]          r_cand;
    logic                      r_cand_vld;
    logic [LC_W-1:0]           r_lvl;
    logic [LEN_W-1:0]          r_idx;
    t_out_item                 r_out, n_out;

    logic [LEN_W-1:0]  eff_len;
    logic [POS_W:0]    sum_in, sum_q;
    logic [POS_W-1:0]  mid_in, mid_q;
    logic [POS_W-1:0]  w_lo, w_hi, second;
    logic [LEN_W-1:0]  len, pow;
    logic [FL_W-1:0]   fl;
    logic [LA_W-1:0]   q;
    logic [LEN_W-1:0]  half;
    logic [LA_W-1:0]   blvl;
    logic [AW-1:0]     rd_addr_a, rd_addr_b, wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic              wr_en, load_ok;
    logic [SPAN_W-1:0] bld_end;
    logic signed [VALUE_BITS-1:0] min_ab;
    logic signed [CMP_W-1:0] m_ext, thr_ext;
    logic signed [SRCH_W-1:0] mid_s;
    logic              set_cand;

    always_comb begin
        eff_len = (int'(r_used_len) > MAX_ELEMENTS) ? LEN_W'(MAX_ELEMENTS) : r_used_len;
        load_ok = int'(i_in_data.left) < MAX_ELEMENTS;
        sum_in  = {1'b0, i_in_data.left} + {1'b0, i_in_data.right};
        mid_in  = sum_in[POS_W:1];
        sum_q   = {1'b0, r_lo[POS_W-1:0]} + {1'b0, r_hi[POS_W-1:0]};
        mid_q   = sum_q[POS_W:1];
    end

    // two overlapping power-of-two windows over [w_lo, w_hi]
    always_comb begin
        w_lo = r_lo[POS_W-1:0];
        w_hi = (r_op == OP_RMIN) ? r_hi[POS_W-1:0] : mid_q;
        if (i_cmd.rd_sel == RD_INPUT) begin
            w_lo = i_in_data.left;
            w_hi = (i_in_data.op == OP_RMIN) ? i_in_data.right : mid_in;
        end
        len = {1'b0, w_hi} - {1'b0, w_lo} + LEN_W'(1);
        fl  = '0;
        for (int b = 0; b < LEN_W; b++) begin
            if (len[b]) fl = FL_W'(b);
        end
        q      = (int'(fl) > LEVELS - 1) ? LA_W'(LEVELS - 1) : LA_W'(fl);
        pow    = LEN_W'(1) << q;
        second = POS_W'({1'b0, w_hi} + LEN_W'(1) - pow);
    end

    always_comb begin
        blvl    = LA_W'(r_lvl - LC_W'(1));
        half    = LEN_W'(1) << (r_lvl - LC_W'(1));
        bld_end = SPAN_W'(r_idx) + (SPAN_W'(1) << r_lvl);
        min_ab  = (r_rd_a < r_rd_b) ? r_rd_a : r_rd_b;
        if (i_cmd.rd_sel == RD_BUILD) begin
            rd_addr_a = {blvl, IDX_W'(r_idx)};
            rd_addr_b = {blvl, IDX_W'(r_idx + half)};
        end else begin
            rd_addr_a = {q, IDX_W'(w_lo)};
            rd_addr_b = {q, IDX_W'(second)};
        end
        if (i_cmd.bld_wr) begin
            wr_addr = {LA_W'(r_lvl), IDX_W'(r_idx)};
            wr_data = min_ab;
        end else begin
            wr_addr = {LA_W'(0), IDX_W'(i_in_data.left)};
            wr_data = VALUE_BITS'($unsigned(i_in_data.value));
        end
        wr_en = i_cmd.bld_wr || (i_cmd.load_wr && load_ok);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        r_rd_a <= r_table[rd_addr_a];
        r_rd_b <= r_table[rd_addr_b];
    end

    // one binary-search step
    always_comb begin
        m_ext    = CMP_W'(min_ab);
        thr_ext  = CMP_W'(r_thr);
        mid_s    = $signed({2'b00, mid_q});
        n_lo     = r_lo;
        n_hi     = r_hi;
        set_cand = 1'b0;
        if (r_op == OP_SRCH_LO) begin
            if (m_ext < thr_ext) begin
                n_lo = mid_s + ONE_S;
            end else begin
                n_hi     = mid_s - ONE_S;
                set_cand = 1'b1;
            end
        end else begin
            if (m_ext > thr_ext) begin
                n_hi = mid_s - ONE_S;
            end else begin
                n_lo     = mid_s + ONE_S;
                set_cand = 1'b1;
            end
        end
    end

    always_comb begin
        o_status.in_op        = i_in_data.op;
        o_status.in_err       = !r_built || (i_in_data.left > i_in_data.right)
                                || ({1'b0, i_in_data.right} >= eff_len);
        o_status.bld_ok       = (r_lvl < LC_W'(LEVELS)) && (bld_end <= SPAN_W'(eff_len));
        o_status.bld_idx_zero = (r_idx == '0);
        o_status.srch_more    = (n_lo <= n_hi);
    end

    always_comb begin
        n_out = '0;
        unique case (i_cmd.out_sel)
            OUT_ZERO: n_out = '0;
            OUT_ERR:  n_out.range_error = 1'b1;
            OUT_RMIN: n_out.min_value = m_ext[FIELD_W-1:0];
            OUT_SRCH: begin
                n_out.position = r_cand_vld ? r_cand : '0;
                n_out.found    = r_cand_vld;
            end
            default:  n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_len <= LEN_W'(1024);
            r_built    <= 1'b0;
        end else begin
            priority if (i_cfg_wr_en) begin
                r_used_len <= i_cfg_wr_data;
                r_built    <= 1'b0;
            end else if (i_cmd.set_built) begin
                r_built <= 1'b1;
            end else if (i_cmd.load_wr && load_ok) begin
                r_built <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_in_data.op;
            r_thr      <= i_in_data.value;
            r_lo       <= $signed({2'b00, i_in_data.left});
            r_hi       <= $signed({2'b00, i_in_data.right});
            r_cand_vld <= 1'b0;
            r_lvl      <= LC_W'(1);
            r_idx      <= '0;
        end else begin
            if (i_cmd.srch_step) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
                if (set_cand) begin
                    r_cand     <= mid_q;
                    r_cand_vld <= 1'b1;
                end
            end
            if (i_cmd.bld_wr) begin
                r_idx <= r_idx + LEN_W'(1);
            end
            if (i_cmd.bld_next_lvl) begin
                r_lvl <= r_lvl + LC_W'(1);
                r_idx <= '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    `ASSERT_IMPLIES(a_bld_wr_in_range, i_clk, i_rst_n, i_cmd.bld_wr, o_status.bld_ok, "build write outside window")
    `ASSERT_IMPLIES(a_srch_bounds, i_clk, i_rst_n, i_cmd.srch_step, (r_lo <= r_hi), "search step with empty bounds")

endmodule

[rtl/sparse_table_range_min_top.sv]
// Load and unknown ops: result registered at the acceptance edge if the result register is free, else via S_PUT.
// Range min: one registered two-port table read, then the result register.
// Search: per iteration a registered table read, then a compare step, iterations <= log2(right - left + 1) + 1.
// Build: per table entry written a read (S_BRD) then a write (S_BWR), per level visited a step to the next level.
// Reset (i_rst_n low, synchronous): idle, no result pending, used_length 1024,
// table not built; table contents stay undefined until loaded.
module sparse_table_range_min_top #(
    parameter int MAX_ELEMENTS = strm_pkg::MAX_ELEMENTS_DEF,
    parameter int LEVELS       = strm_pkg::LEVELS_DEF,
    parameter int VALUE_BITS   = strm_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  strm_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output strm_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_wr_en,
    input  logic [strm_pkg::LEN_W-1:0] i_cfg_wr_data
);
    import strm_pkg::*;

    t_cmd    cmd;
    t_status status;

    strm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    strm_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_data    (o_out_data)
    );

endmodule
